/* rtl/fuae_pkg.sv */
`timescale 1ns / 1ps
package fuae_pkg;

    localparam int DW = 64;
    localparam int MW = 63;
    localparam int EW = 11;
    localparam int FW = 52;
    localparam int LW = 31;
    localparam int SW = 56;

    localparam logic [MW-1:0] MIN_NORMAL_MAG = 63'h0010_0000_0000_0000;
    localparam logic [MW-1:0] INF_MAG        = 63'h7FF0_0000_0000_0000;
    localparam logic [EW-1:0] EXP_ONES       = 11'h7FF;
    localparam logic [DW-1:0] NEG_ZERO       = 64'h8000_0000_0000_0000;
    localparam logic [LW-1:0] MAX_ULP_RESET  = 31'd4;

    localparam logic CFG_ABS_TOL = 1'b0;
    localparam logic CFG_MAX_ULP = 1'b1;

    typedef struct packed {
        logic          eq;
        logic          naninf;
        logic          a_zero;
        logic          b_zero;
        logic          same_sign;
        logic [MW-1:0] dz_a;
        logic [MW-1:0] dz_b;
        logic [MW-1:0] dab;
        logic [EW-1:0] ex;
        logic [EW-1:0] dexp;
        logic [FW:0]   sx;
        logic [FW:0]   sy;
    } s2_t;

    typedef struct packed {
        logic          eq;
        logic          naninf;
        logic          ulp_pass;
        logic          sub_op;
        logic [EW-1:0] ex;
        logic [SW-1:0] x56;
        logic [SW-1:0] y56;
    } s3_t;

    typedef struct packed {
        logic          eq;
        logic          naninf;
        logic          ulp_pass;
        logic [EW-1:0] ex;
        logic [SW:0]   sum;
    } s4_t;

    typedef struct packed {
        logic          eq;
        logic          naninf;
        logic          ulp_pass;
        logic          ovf;
        logic [MW-1:0] pat;
        logic          round_up;
    } s5_t;

    // Count of leading zeros of the 56-bit working significand.
    function automatic logic [5:0] lzc56(input logic [SW-1:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd56;
        found = 1'b0;
        for (int i = SW - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(SW - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* rtl/fuae_if.sv */
`timescale 1ns / 1ps
interface fuae_req_if;
    logic                    valid;
    logic                    ready;
    logic [fuae_pkg::DW-1:0] first_value;
    logic [fuae_pkg::DW-1:0] second_value;

    modport source (output valid, output first_value, output second_value, input ready);
    modport sink (input valid, input first_value, input second_value, output ready);
endinterface

interface fuae_rsp_if;
    logic valid;
    logic ready;
    logic approx_equal;

    modport source (output valid, output approx_equal, input ready);
    modport sink (input valid, input approx_equal, output ready);
endinterface

/* rtl/float_ulp_approx_equal.sv */
`timescale 1ns / 1ps
// A request passes through a_reg/b_reg, s2_reg, s3_reg, s4_reg, s5_reg and out_reg in turn.
// Throughput: one request per cycle while rsp.ready is high; six register stages, each with its own valid bit.
// A stage takes new data whenever it is empty or its successor moves, so a waiting
// result never blocks requests while an earlier stage has room.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets the tolerance
// to +0.0 and the ULP limit to 4.
module float_ulp_approx_equal (
    input  logic                                  clk,
    input  logic                                  rst_n,
    fuae_req_if.sink                              req,
    fuae_rsp_if.source                            rsp,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [fuae_pkg::DW-1:0]               cfg_wdata
);
    import fuae_pkg::*;

    // Configuration registers.
    logic [DW-1:0] abs_tol_reg;
    logic [LW-1:0] max_ulp_reg;

    // Pipeline valid bits and per-stage advance enables.
    logic [5:0] vld_reg;
    logic [5:0] adv;

    logic [DW-1:0] a_reg;
    logic [DW-1:0] b_reg;
    s2_t           s2_reg;
    s2_t           s2_next;
    s3_t           s3_reg;
    s3_t           s3_next;
    s4_t           s4_reg;
    s4_t           s4_next;
    s5_t           s5_reg;
    s5_t           s5_next;
    logic          out_reg;
    logic          out_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            abs_tol_reg <= '0;
            max_ulp_reg <= MAX_ULP_RESET;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ABS_TOL: abs_tol_reg <= cfg_wdata;
                CFG_MAX_ULP: max_ulp_reg <= cfg_wdata[LW-1:0];
                default:     abs_tol_reg <= abs_tol_reg;
            endcase
        end
    end

    // A stage may load when it is empty or when its contents move on.
    always_comb begin
        adv[5] = !vld_reg[5] || rsp.ready;
        for (int k = 4; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign req.ready        = adv[0];
    assign rsp.valid        = vld_reg[5];
    assign rsp.approx_equal = out_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (adv[0]) begin
                vld_reg[0] <= req.valid;
            end
            for (int k = 1; k < 6; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Stage A: classify, flush subnormals, order by magnitude, and take the
    // integer distances that the ULP rules need.
    always_comb begin
        logic          nan_a;
        logic          nan_b;
        logic [DW-1:0] fa;
        logic [DW-1:0] fb;
        logic [DW-1:0] xv;
        logic [DW-1:0] yv;
        logic [EW-1:0] ey;

        nan_a = a_reg[62:52] == EXP_ONES;
        nan_b = b_reg[62:52] == EXP_ONES;
        fa    = (a_reg[62:52] == '0) ? '0 : a_reg;
        fb    = (b_reg[62:52] == '0) ? '0 : b_reg;

        s2_next.eq = !(nan_a && a_reg[51:0] != '0) && !(nan_b && b_reg[51:0] != '0)
                     && ((a_reg == b_reg) || (a_reg[62:0] == '0 && b_reg[62:0] == '0));
        s2_next.naninf    = nan_a || nan_b;
        s2_next.a_zero    = fa[62:0] == '0;
        s2_next.b_zero    = fb[62:0] == '0;
        s2_next.same_sign = fa[63] == fb[63];
        s2_next.dz_a = (fa[62:0] >= MIN_NORMAL_MAG) ? fa[62:0] - MIN_NORMAL_MAG
                                                    : MIN_NORMAL_MAG - fa[62:0];
        s2_next.dz_b = (fb[62:0] >= MIN_NORMAL_MAG) ? fb[62:0] - MIN_NORMAL_MAG
                                                    : MIN_NORMAL_MAG - fb[62:0];
        s2_next.dab  = (fa[62:0] >= fb[62:0]) ? fa[62:0] - fb[62:0] : fb[62:0] - fa[62:0];

        xv = (fa[62:0] >= fb[62:0]) ? fa : fb;
        yv = (fa[62:0] >= fb[62:0]) ? fb : fa;
        s2_next.ex   = xv[62:52];
        ey           = yv[62:52];
        s2_next.dexp = xv[62:52] - ey;
        s2_next.sx   = (xv[62:52] == '0) ? '0 : {1'b1, xv[51:0]};
        s2_next.sy   = (ey == '0) ? '0 : {1'b1, yv[51:0]};
    end

    // Stage B: align the smaller significand with guard, round and sticky bits,
    // and settle the ULP rules against the limit.
    always_comb begin
        logic [116:0] sh;
        logic         lt_a;
        logic         lt_b;
        logic [32:0]  opp_sum;

        s3_next.eq     = s2_reg.eq;
        s3_next.naninf = s2_reg.naninf;
        s3_next.sub_op = s2_reg.same_sign;
        s3_next.ex     = s2_reg.ex;
        s3_next.x56    = {s2_reg.sx, 3'b000};
        sh = {s2_reg.sy, 64'b0} >> s2_reg.dexp[5:0];
        if (s2_reg.dexp > 11'd60) begin
            s3_next.y56 = {55'b0, |s2_reg.sy};
        end
        else begin
            s3_next.y56 = {sh[116:62], |sh[61:0]};
        end

        lt_a = s2_reg.dz_a[62:31] == '0 && s2_reg.dz_a[30:0] < max_ulp_reg;
        lt_b = s2_reg.dz_b[62:31] == '0 && s2_reg.dz_b[30:0] < max_ulp_reg;
        opp_sum = 33'd2 + {2'b0, s2_reg.dz_a[30:0]} + {2'b0, s2_reg.dz_b[30:0]};
        if (s2_reg.a_zero) begin
            s3_next.ulp_pass = lt_b;
        end
        else if (s2_reg.b_zero) begin
            s3_next.ulp_pass = lt_a;
        end
        else if (s2_reg.same_sign) begin
            s3_next.ulp_pass = s2_reg.dab[62:31] == '0 && s2_reg.dab[30:0] <= max_ulp_reg;
        end
        else begin
            s3_next.ulp_pass = lt_a && lt_b && opp_sum <= {2'b0, max_ulp_reg};
        end
    end

    // Stage C: the magnitude add or subtract. Equal signs subtract magnitudes.
    always_comb begin
        s4_next.eq       = s3_reg.eq;
        s4_next.naninf   = s3_reg.naninf;
        s4_next.ulp_pass = s3_reg.ulp_pass;
        s4_next.ex       = s3_reg.ex;
        if (s3_reg.sub_op) begin
            s4_next.sum = {1'b0, s3_reg.x56} - {1'b0, s3_reg.y56};
        end
        else begin
            s4_next.sum = {1'b0, s3_reg.x56} + {1'b0, s3_reg.y56};
        end
    end

    // Stage D: normalize. A result below the normal range keeps the shift that
    // brings it to the smallest exponent and is encoded as a subnormal.
    always_comb begin
        logic [5:0]    lz;
        logic [5:0]    shamt;
        logic [SW-1:0] n;
        logic [EW:0]   e;

        s5_next.eq       = s4_reg.eq;
        s5_next.naninf   = s4_reg.naninf;
        s5_next.ulp_pass = s4_reg.ulp_pass;
        lz    = lzc56(s4_reg.sum[SW-1:0]);
        shamt = '0;
        n     = '0;
        e     = '0;
        if (s4_reg.sum[SW]) begin
            n = {s4_reg.sum[SW:2], s4_reg.sum[1] | s4_reg.sum[0]};
            e = {1'b0, s4_reg.ex} + 12'd1;
        end
        else if (s4_reg.ex != '0) begin
            if ({6'b0, lz} >= {1'b0, s4_reg.ex}) begin
                shamt = 6'(s4_reg.ex - 11'd1);
            end
            else begin
                shamt = lz;
            end
            n = s4_reg.sum[SW-1:0] << shamt;
            e = n[SW-1] ? {1'b0, s4_reg.ex} - {6'b0, shamt} : '0;
        end
        s5_next.ovf      = e[EW-1:0] == EXP_ONES;
        s5_next.pat      = {e[EW-1:0], n[54:3]};
        s5_next.round_up = n[2] && (n[1] || n[0] || n[3]);
    end

    // Stage E: round to nearest even, compare with the tolerance, and combine
    // the rules in their order of precedence.
    always_comb begin
        logic [MW-1:0] rnd;
        logic          abs_ok;

        rnd = s5_reg.ovf ? INF_MAG : s5_reg.pat + {62'b0, s5_reg.round_up};
        if (abs_tol_reg == NEG_ZERO) begin
            abs_ok = rnd == '0;
        end
        else begin
            abs_ok = !abs_tol_reg[63] && abs_tol_reg[62:0] <= INF_MAG
                     && rnd <= abs_tol_reg[62:0];
        end
        out_next = s5_reg.eq || (!s5_reg.naninf && (abs_ok || s5_reg.ulp_pass));
    end

    // Payload registers need no reset.
    always_ff @(posedge clk) begin
        if (adv[0]) begin
            a_reg <= req.first_value;
            b_reg <= req.second_value;
        end
        if (adv[1]) begin
            s2_reg <= s2_next;
        end
        if (adv[2]) begin
            s3_reg <= s3_next;
        end
        if (adv[3]) begin
            s4_reg <= s4_next;
        end
        if (adv[4]) begin
            s5_reg <= s5_next;
        end
        if (adv[5]) begin
            out_reg <= out_next;
        end
    end

endmodule
